>>> rtl/eors_pkg.sv
// ---------------------------------------------------------------------------
// eors_pkg: shared types and codes for the extent overlap sweep
// Field widths, operation and status codes, FSM state and the cell command.
// ---------------------------------------------------------------------------
package eors_pkg;

    localparam int END_W       = 49;
    localparam int START_W     = 48;
    localparam int LEN_W       = 32;
    localparam int SEG_START_W = 64;
    localparam int SEG_LEN_W   = 49;
    localparam int REF_W       = 6;
    localparam int STATUS_W    = 2;
    localparam int OP_W        = 2;
    localparam int IN_DATA_W   = 80;
    localparam int OUT_DATA_W  = 128;
    localparam int COW_W       = 64;
    localparam int BAG_DEPTH_DEF = 32;
    localparam logic [COW_W-1:0] COW_RESET = {1'b1, {(COW_W-1){1'b0}}};

    // operation codes
    localparam logic [OP_W-1:0] OP_SHARE = 2'd0;
    localparam logic [OP_W-1:0] OP_COW   = 2'd1;
    localparam logic [OP_W-1:0] OP_SKIP  = 2'd2;
    localparam logic [OP_W-1:0] OP_END   = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] STS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STS_OVERFLOW = 2'd1;
    localparam logic [STATUS_W-1:0] STS_ZERO_LEN = 2'd2;
    localparam logic [STATUS_W-1:0] STS_ORDER    = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLOSE,
        ST_SWEEP,
        ST_INSERT,
        ST_DRAIN,
        ST_FLUSH
    } t_state;

    // broadcast to every cell of the bag
    typedef struct packed {
        logic             ins;
        logic             pop;
        logic [END_W-1:0] val;
    } t_cell_cmd;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [REF_W-1:0]       cnt;
        logic [SEG_LEN_W-1:0]   len;
        logic [SEG_START_W-1:0] start;
    } t_result;

endpackage

>>> rtl/extent_overlap_refcount_sweep.sv
// ---------------------------------------------------------------------------
// extent_overlap_refcount_sweep: overlap count sweep over sorted extents
// Emits shared-block segments, copy-on-write extents and status results.
// ---------------------------------------------------------------------------
// One request at a time. The active ends sit in a chain of BAG_DEPTH cells
// kept sorted, so the smallest end is always in the first cell. Each removed
// end is popped from the first cell, and each distinct end value passed below
// the new start then has its position closed. A shareable request starting
// beyond the sweep position closes, sweeps and inserts; one starting at the
// sweep position only inserts. An end-of-stream request closes and drains
// all ends. Copy-on-write, zero-length and out-of-order requests go straight
// to the flush of their result, an ignored request returns to idle. Output
// stalls can hold the close, overflow and flush steps.
// ---------------------------------------------------------------------------
module extent_overlap_refcount_sweep #(
    parameter int BAG_DEPTH = eors_pkg::BAG_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // config
    input  logic                               i_cfg_we,
    input  logic [eors_pkg::COW_W-1:0]         i_cfg_wdata,   // cow_offset
    // input stream
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [eors_pkg::IN_DATA_W-1:0]     i_s_tdata,     // start_block, block_count
    input  logic [eors_pkg::OP_W-1:0]          i_s_tuser,     // operation
    // output stream
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [eors_pkg::OUT_DATA_W-1:0]    o_m_tdata,     // seg_start, seg_length,
                                                              // ref_count, status
    output logic                               o_m_tlast      // last_of_run
);
    import eors_pkg::*;

    localparam int CW  = $clog2(BAG_DEPTH + 1);
    localparam int CWX = (CW > REF_W) ? CW : REF_W;

    t_state              r_state, n_state;
    logic [OP_W-1:0]     r_op, n_op;
    logic [START_W-1:0]  r_s, n_s;
    logic [LEN_W-1:0]    r_len, n_len;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_prev, n_prev;
    logic [END_W-1:0]    r_segb, n_segb;
    logic [END_W-1:0]    r_sweep, n_sweep;
    logic [COW_W-1:0]    r_cow;
    logic                r_pend_v, n_pend_v;
    t_result             r_pend, n_pend;
    logic                r_out_v, n_out_v;
    t_result             r_out, n_out;
    logic                r_out_last, n_out_last;

    t_cell_cmd           w_cmd;
    logic                w_v   [BAG_DEPTH];
    logic [END_W-1:0]    w_end [BAG_DEPTH];
    logic                w_le  [BAG_DEPTH];
    logic [BAG_DEPTH-1:0] w_vvec;

    logic                w_out_free;
    logic                w_can;
    logic                w_accept;
    logic [START_W-1:0]  w_in_s;
    logic [LEN_W-1:0]    w_in_len;
    logic [END_W-1:0]    w_s49;
    logic [CWX-1:0]      w_prev_x;
    t_result             w_close_res;
    t_result             w_stat_res;
    logic                w_head_v;
    logic [END_W-1:0]    w_head;
    logic                w_dup;

    // cell chain
    for (genvar g = 0; g < BAG_DEPTH; g++) begin : g_cell
        logic             w_lv, w_lle, w_rv;
        logic [END_W-1:0] w_lend, w_rend;
        if (g == 0) begin : g_first
            assign w_lv   = 1'b0;
            assign w_lend = '0;
            assign w_lle  = 1'b1;
        end else begin : g_mid
            assign w_lv   = w_v[g-1];
            assign w_lend = w_end[g-1];
            assign w_lle  = w_le[g-1];
        end
        if (g == BAG_DEPTH - 1) begin : g_last
            assign w_rv   = 1'b0;
            assign w_rend = '0;
        end else begin : g_inner
            assign w_rv   = w_v[g+1];
            assign w_rend = w_end[g+1];
        end
        eors_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_cmd       (w_cmd),
            .i_left_v    (w_lv),
            .i_left_end  (w_lend),
            .i_left_le   (w_lle),
            .i_right_v   (w_rv),
            .i_right_end (w_rend),
            .o_v         (w_v[g]),
            .o_end       (w_end[g]),
            .o_le        (w_le[g])
        );
        assign w_vvec[g] = w_v[g];
    end

    // handshake and field decode
    assign o_s_tready = (r_state == ST_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_in_s     = i_s_tdata[START_W-1:0];
    assign w_in_len   = i_s_tdata[START_W+LEN_W-1:START_W];
    assign w_out_free = !r_out_v || i_m_tready;
    assign w_can      = !r_pend_v || w_out_free;
    assign w_s49      = {1'b0, r_s};
    assign w_prev_x   = CWX'(r_prev);
    assign w_head_v   = w_v[0];
    assign w_head     = w_end[0];
    assign w_dup      = w_v[1] && (w_end[1] == w_head);

    always_comb begin
        w_close_res.start  = SEG_START_W'(r_segb);
        w_close_res.len    = r_sweep - r_segb;
        w_close_res.cnt    = w_prev_x[REF_W-1:0];
        w_close_res.status = STS_OK;
        w_stat_res         = '0;
    end

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_s        = r_s;
        n_len      = r_len;
        n_count    = r_count;
        n_prev     = r_prev;
        n_segb     = r_segb;
        n_sweep    = r_sweep;
        n_pend_v   = r_pend_v;
        n_pend     = r_pend;
        n_out_v    = r_out_v && !i_m_tready;
        n_out      = r_out;
        n_out_last = r_out_last;
        w_cmd.ins  = 1'b0;
        w_cmd.pop  = 1'b0;
        w_cmd.val  = w_s49 + END_W'(r_len);

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_op  = i_s_tuser;
                    n_s   = w_in_s;
                    n_len = w_in_len;
                    unique case (i_s_tuser)
                        OP_COW: begin
                            n_pend_v = 1'b1;
                            n_state  = ST_FLUSH;
                            if (w_in_len == '0) begin
                                n_pend        = w_stat_res;
                                n_pend.status = STS_ZERO_LEN;
                            end else begin
                                n_pend.start  = SEG_START_W'(w_in_s) + r_cow;
                                n_pend.len    = SEG_LEN_W'(w_in_len);
                                n_pend.cnt    = REF_W'(1);
                                n_pend.status = STS_OK;
                            end
                        end
                        OP_SHARE: begin
                            if (w_in_len == '0) begin
                                n_pend        = w_stat_res;
                                n_pend.status = STS_ZERO_LEN;
                                n_pend_v      = 1'b1;
                                n_state       = ST_FLUSH;
                            end else if ({1'b0, w_in_s} < r_sweep) begin
                                n_pend        = w_stat_res;
                                n_pend.status = STS_ORDER;
                                n_pend_v      = 1'b1;
                                n_state       = ST_FLUSH;
                            end else if ({1'b0, w_in_s} == r_sweep) begin
                                n_state = ST_INSERT;
                            end else begin
                                n_state = ST_CLOSE;
                            end
                        end
                        OP_END:  n_state = ST_CLOSE;
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_CLOSE: begin
                if (r_count == r_prev) begin
                    n_state = (r_op == OP_END) ? ST_DRAIN : ST_SWEEP;
                end else if (r_prev <= CW'(1) || w_can) begin
                    if (r_prev > CW'(1)) begin
                        if (r_pend_v) begin
                            n_out_v    = 1'b1;
                            n_out      = r_pend;
                            n_out_last = 1'b0;
                        end
                        n_pend_v = 1'b1;
                        n_pend   = w_close_res;
                    end
                    n_segb  = r_sweep;
                    n_prev  = r_count;
                    n_state = (r_op == OP_END) ? ST_DRAIN : ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                if (w_head_v && w_head <= w_s49) begin
                    n_sweep   = w_head;
                    w_cmd.pop = 1'b1;
                    n_count   = r_count - CW'(1);
                    if (!w_dup && w_head < w_s49) begin
                        n_state = ST_CLOSE;
                    end
                end else begin
                    n_sweep = w_s49;
                    n_state = ST_INSERT;
                end
            end
            ST_INSERT: begin
                if (r_count >= CW'(BAG_DEPTH)) begin
                    if (w_can) begin
                        if (r_pend_v) begin
                            n_out_v    = 1'b1;
                            n_out      = r_pend;
                            n_out_last = 1'b0;
                        end
                        n_pend_v      = 1'b1;
                        n_pend        = w_stat_res;
                        n_pend.status = STS_OVERFLOW;
                        n_state       = ST_FLUSH;
                    end
                end else begin
                    w_cmd.ins = 1'b1;
                    n_count   = r_count + CW'(1);
                    n_state   = ST_FLUSH;
                end
            end
            ST_DRAIN: begin
                if (w_head_v) begin
                    n_sweep   = w_head;
                    w_cmd.pop = 1'b1;
                    n_count   = r_count - CW'(1);
                    if (!w_dup) begin
                        n_state = ST_CLOSE;
                    end
                end else begin
                    n_sweep = '0;
                    n_segb  = '0;
                    n_prev  = r_count;
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (!r_pend_v) begin
                    n_state = ST_IDLE;
                end else if (w_out_free) begin
                    n_out_v    = 1'b1;
                    n_out      = r_pend;
                    n_out_last = 1'b1;
                    n_pend_v   = 1'b0;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state and payload registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_prev   <= '0;
            r_segb   <= '0;
            r_sweep  <= '0;
            r_cow    <= COW_RESET;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_prev   <= n_prev;
            r_segb   <= n_segb;
            r_sweep  <= n_sweep;
            r_pend_v <= n_pend_v;
            r_out_v  <= n_out_v;
            if (i_cfg_we) begin
                r_cow <= i_cfg_wdata;
            end
        end
        r_op       <= n_op;
        r_s        <= n_s;
        r_len      <= n_len;
        r_pend     <= n_pend;
        r_out      <= n_out;
        r_out_last <= n_out_last;
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = OUT_DATA_W'(r_out);
    assign o_m_tlast  = r_out_last;

    // checks
    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == CW'($countones(w_vvec)))
        else $error("active count differs from occupied cells");
    a_head_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_v[1] |-> w_v[0])
        else $error("bag chain has a hole at its head");
    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_pend_v)
        else $error("pending result left behind at idle");
    a_sorted_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_v[1] |-> (w_end[0] <= w_end[1]))
        else $error("bag chain out of order");

endmodule

>>> rtl/eors_cell.sv
// ---------------------------------------------------------------------------
// eors_cell: one slot of the sorted end-position chain
// Holds one end; inserts shift larger ends right, a pop shifts all left.
// ---------------------------------------------------------------------------
module eors_cell (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  eors_pkg::t_cell_cmd             i_cmd,
    input  logic                            i_left_v,
    input  logic [eors_pkg::END_W-1:0]      i_left_end,
    input  logic                            i_left_le,
    input  logic                            i_right_v,
    input  logic [eors_pkg::END_W-1:0]      i_right_end,
    output logic                            o_v,
    output logic [eors_pkg::END_W-1:0]      o_end,
    output logic                            o_le
);
    import eors_pkg::*;

    logic             r_v;
    logic [END_W-1:0] r_end;
    logic             n_v;
    logic [END_W-1:0] n_end;

    // this slot holds an end at or below the value being inserted
    assign o_le  = r_v && (r_end <= i_cmd.val);
    assign o_v   = r_v;
    assign o_end = r_end;

    always_comb begin
        n_v   = r_v;
        n_end = r_end;
        if (i_cmd.pop) begin
            n_v   = i_right_v;
            n_end = i_right_end;
        end else if (i_cmd.ins && !o_le) begin
            if (i_left_le) begin
                n_v   = 1'b1;
                n_end = i_cmd.val;
            end else if (i_left_v) begin
                n_v   = 1'b1;
                n_end = i_left_end;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else begin
            r_v <= n_v;
        end
        r_end <= n_end;
    end

endmodule

>>> tb/sv/extent_overlap_refcount_sweep_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// extent_overlap_refcount_sweep_tb: self-checking bench for the overlap sweep
// Drives mostly sorted extent requests with random gaps, predicts the emitted
// segments with a behavioral sweep of its own, and checks every result.
// ---------------------------------------------------------------------------
module extent_overlap_refcount_sweep_tb;
    import eors_pkg::*;

    localparam int DEPTH     = 32;
    localparam int CYC_LIMIT = 2000000;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [START_W-1:0] start;
        logic [LEN_W-1:0]   len;
    } t_req;

    typedef struct packed {
        logic [SEG_START_W-1:0] start;
        logic [SEG_LEN_W-1:0]   len;
        logic [REF_W-1:0]       cnt;
        logic [STATUS_W-1:0]    status;
        logic                   last;
    } t_seg;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [COW_W-1:0]       i_cfg_wdata = '0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [IN_DATA_W-1:0]   i_s_tdata = '0;
    logic [OP_W-1:0]        i_s_tuser = '0;
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  o_m_tdata;
    logic                   o_m_tlast;

    extent_overlap_refcount_sweep dut (.*);

    always #5 i_clk = ~i_clk;

    // predictor state
    logic [COW_W-1:0]   cow_off;
    logic [END_W-1:0]   bag_end [DEPTH];
    logic               bag_vld [DEPTH];
    int unsigned        live_cnt, prev_cnt;
    logic [END_W-1:0]   seg_begin, sweep_pos;

    t_req   pending_reqs[$];
    t_seg   expected_segs[$];
    int     mismatches = 0;
    int     cycles = 0;
    bit     rcv_hold = 1'b0;

    task automatic push_seg(input logic [63:0] st, input logic [END_W-1:0] ln,
                            input int unsigned c, input logic [STATUS_W-1:0] sts);
        t_seg r;
        r.start = st; r.len = ln; r.cnt = c[REF_W-1:0]; r.status = sts; r.last = 1'b0;
        expected_segs.push_back(r);
    endtask

    task automatic close_at();
        if (live_cnt != prev_cnt) begin
            if (prev_cnt > 1)
                push_seg({15'd0, seg_begin}, sweep_pos - seg_begin, prev_cnt, STS_OK);
            seg_begin = sweep_pos;
            prev_cnt  = live_cnt;
        end
    endtask

    function automatic bit lowest_end(output logic [END_W-1:0] e);
        bit found;
        found = 0; e = '0;
        for (int i = 0; i < DEPTH; i++)
            if (bag_vld[i] && (!found || bag_end[i] < e)) begin
                e = bag_end[i]; found = 1;
            end
        return found;
    endfunction

    task automatic retire_ends(input logic [END_W-1:0] e);
        for (int i = 0; i < DEPTH; i++)
            if (bag_vld[i] && bag_end[i] == e) begin
                bag_vld[i] = 0;
                if (live_cnt > 0) live_cnt--;
            end
    endtask

    task automatic predict_sweep(input t_req r);
        logic [END_W-1:0] e, s;
        int n0;
        n0 = expected_segs.size();
        s = {1'b0, r.start};
        case (r.op)
            OP_SKIP: ;
            OP_COW:
                if (r.len == 0) push_seg('0, '0, 0, STS_ZERO_LEN);
                else push_seg({16'd0, r.start} + cow_off, {17'd0, r.len}, 1, STS_OK);
            OP_SHARE:
                if (r.len == 0) push_seg('0, '0, 0, STS_ZERO_LEN);
                else if (s < sweep_pos) push_seg('0, '0, 0, STS_ORDER);
                else begin
                    if (s > sweep_pos) begin
                        close_at();
                        while (lowest_end(e) && e <= s) begin
                            sweep_pos = e;
                            retire_ends(e);
                            if (e < s) close_at();
                        end
                        sweep_pos = s;
                    end
                    if (live_cnt >= DEPTH) push_seg('0, '0, 0, STS_OVERFLOW);
                    else begin
                        for (int i = 0; i < DEPTH; i++)
                            if (!bag_vld[i]) begin
                                bag_vld[i] = 1; bag_end[i] = s + r.len; live_cnt++;
                                break;
                            end
                    end
                end
            default: begin
                close_at();
                while (lowest_end(e)) begin
                    sweep_pos = e;
                    retire_ends(e);
                    close_at();
                end
                sweep_pos = '0; seg_begin = '0; prev_cnt = live_cnt;
            end
        endcase
        if (expected_segs.size() > n0)
            expected_segs[expected_segs.size()-1].last = 1'b1;
    endtask

    // driver: one request from the queue, random gap after each
    int src_gap = 0;
    always @(posedge i_clk) begin
        t_req r;
        if (i_s_tvalid && o_s_tready) begin
            predict_sweep({i_s_tuser, i_s_tdata[START_W-1:0], i_s_tdata[79:48]});
        end
        if (i_rst_n && !(i_s_tvalid && !o_s_tready)) begin
            if (src_gap > 0) begin
                src_gap <= src_gap - 1;
                i_s_tvalid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                r = pending_reqs.pop_front();
                i_s_tvalid <= 1'b1;
                i_s_tuser  <= r.op;
                i_s_tdata  <= {r.len, r.start};
                src_gap    <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
            end else
                i_s_tvalid <= 1'b0;
        end
    end

    // monitor: random back-pressure, compare with the oldest expectation
    int dst_gap = 0;
    always @(posedge i_clk) begin
        t_seg x, a;
        if (o_m_tvalid && i_m_tready) begin
            a.start  = o_m_tdata[63:0];
            a.len    = o_m_tdata[112:64];
            a.cnt    = o_m_tdata[118:113];
            a.status = o_m_tdata[120:119];
            a.last   = o_m_tlast;
            if (expected_segs.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", a);
            end else begin
                x = expected_segs.pop_front();
                if (x != a) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp start %h len %h cnt %0d sts %0d last %b | got start %h len %h cnt %0d sts %0d last %b",
                                 x.start, x.len, x.cnt, x.status, x.last,
                                 a.start, a.len, a.cnt, a.status, a.last);
                end
            end
        end
        if (!i_rst_n || rcv_hold) i_m_tready <= 1'b0;
        else if (dst_gap > 0) begin
            dst_gap <= dst_gap - 1; i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
            if (o_m_tvalid)
                dst_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
        end
    end

    // long receiver hold-off while the sender keeps offering
    initial begin
        wait (i_rst_n && pending_reqs.size() > 20);
        repeat (20) @(posedge i_clk);
        rcv_hold <= 1'b1;
        repeat (600) @(posedge i_clk);
        rcv_hold <= 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYC_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic add(input logic [OP_W-1:0] op, input logic [START_W-1:0] s,
                       input logic [LEN_W-1:0] l);
        t_req r;
        r.op = op; r.start = s; r.len = l;
        pending_reqs.push_back(r);
    endtask

    task automatic wait_idle();
        while (pending_reqs.size() > 0 || i_s_tvalid || expected_segs.size() > 0)
            @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_cow(input logic [COW_W-1:0] v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_wdata <= v; cow_off = v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // random run: mostly sorted extents, some flagged, closed by end of stream
    task automatic random_run(input int n, input logic [START_W-1:0] base,
                              input bit wide);
        logic [START_W-1:0] pos;
        pos = base;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 19))
                0: add(OP_COW, START_W'({$urandom, $urandom}),
                       $urandom_range(0, 1) ? $urandom : 0);
                1: add(OP_SKIP, START_W'({$urandom, $urandom}), $urandom);
                2: add(OP_SHARE, pos, 0);
                3: add(OP_SHARE, (pos > 0) ? pos - 1 : pos, $urandom_range(1, 9));
                default: begin
                    if ($urandom_range(0, 2) != 0) pos = pos + $urandom_range(0, 4);
                    add(OP_SHARE, pos, wide ? $urandom : $urandom_range(1, 12));
                end
            endcase
        end
        add(OP_END, START_W'({$urandom, $urandom}), $urandom);
    endtask

    initial begin
        int items;
        cow_off = COW_RESET;
        for (int i = 0; i < DEPTH; i++) begin
            bag_vld[i] = 0; bag_end[i] = '0;
        end
        live_cnt = 0; prev_cnt = 0; seg_begin = '0; sweep_pos = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: every operation, field extremes and each flagged case
        add(OP_COW, '1, '1);
        add(OP_COW, '0, 0);
        add(OP_SKIP, '1, '1);
        add(OP_SHARE, 10, 5);
        add(OP_SHARE, 10, 5);
        add(OP_SHARE, 12, 1);
        add(OP_SHARE, 12, 0);
        add(OP_SHARE, 3, 4);
        add(OP_SHARE, 20, 2);
        add(OP_END, '0, '0);
        add(OP_END, '1, '1);
        add(OP_SHARE, '1, '1);
        add(OP_SHARE, '1, '1);
        add(OP_END, 0, 0);
        for (int i = 0; i < 34; i++) add(OP_SHARE, 100, 7 + (i % 3));
        add(OP_SHARE, 108, 1);
        add(OP_END, 0, 0);
        wait_idle();
        write_cow('0);
        add(OP_COW, '1, 1);
        wait_idle();
        write_cow('1);
        add(OP_COW, 2, 3);
        wait_idle();

        // random phases with several offset settings
        items = 0;
        while (items < 415) begin
            int n;
            n = $urandom_range(5, 40);
            random_run(n, START_W'({$urandom, $urandom}) &
                              (($urandom_range(0, 1)) ? 48'hFF : '1),
                       $urandom_range(0, 5) == 0);
            items += n + 1;
            if ($urandom_range(0, 4) == 0) begin
                wait_idle();
                write_cow({$urandom, $urandom});
            end
        end
        wait_idle();
        write_cow(COW_RESET);
        add(OP_COW, 5, 5);
        wait_idle();

        if (mismatches == 0 && expected_segs.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
